@@ src/sra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_pkg - shared types and constants of the selective repeat sender
// Beat layouts, action and status codes, internal command codes and the
// defaults of the top level parameters and configuration registers.
// ----------------------------------------------------------------------------
package sra_pkg;

  // parameter defaults
  localparam int QUEUE_DEPTH_DEFAULT = 128;
  localparam int WINDOW_MAX_DEFAULT  = 64;

  // field widths
  localparam int FRAME_W    = 8;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 32;
  localparam int WINDOW_W   = 7;
  localparam int FCOUNT_W   = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'b1;
  localparam logic [WINDOW_W-1:0]  WINDOW_RESET    = 7'd4;
  localparam logic [FCOUNT_W-1:0]  FCOUNT_RESET    = 8'd8;

  // action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_SEND  = 2'd1;
  localparam logic [1:0] ACT_ACK   = 2'd2;
  localparam logic [1:0] ACT_UNDEF = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_STARTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SENT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACKED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOST    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd5;

  // request beat
  typedef struct packed {
    logic [1:0] action;
    logic       ack_ok;
  } req_t;

  // result beat
  typedef struct packed {
    logic [FRAME_W-1:0]  frame_number;
    logic [STATUS_W-1:0] status;
    logic                last;
    logic                transfer_done;
    logic [COUNT_W-1:0]  sent_count;
    logic [COUNT_W-1:0]  acked_count;
  } rsp_t;

  // classified command, front to back
  typedef enum logic [2:0] {
    OP_START,
    OP_SEND,
    OP_ACK_OK,
    OP_ACK_LOST,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

endpackage

@@ src/selective_repeat_retransmit_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_retransmit_queue_top - selective repeat sender
// Holds the configuration registers and joins the request front end to the
// execution back end.
//
//   channel  direction  handshake             payload
//   req      in         req_valid / req_stall sra_pkg::req_t
//   rsp      out        rsp_valid / rsp_stall sra_pkg::rsp_t
//   config   in         wr_en (no wait)       wr_index, wr_data
//
// Start writes the pending queue memory one entry per cycle. A send round
// takes one frame per cycle off the queue memory read port while the output
// is not stalled. Reset is synchronous and clears the transfer state; the
// memories are not cleared. An output stall holds the back end; the two
// entry command queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module selective_repeat_retransmit_queue_top #(
  parameter int QUEUE_DEPTH = sra_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int WINDOW_MAX  = sra_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  sra_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output sra_pkg::rsp_t                   rsp,
  input  logic                            wr_en,
  input  logic [sra_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [sra_pkg::CFG_DATA_W-1:0]  wr_data
);

  logic [sra_pkg::WINDOW_W-1:0] win_limit;
  logic [sra_pkg::FCOUNT_W-1:0] frame_count;
  logic                         cmd_valid;
  sra_pkg::cmd_t                cmd;
  logic                         cmd_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_limit   <= sra_pkg::WINDOW_RESET;
      frame_count <= sra_pkg::FCOUNT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        sra_pkg::REG_WIN_LIMIT:   win_limit   <= wr_data[sra_pkg::WINDOW_W-1:0];
        sra_pkg::REG_FRAME_COUNT: frame_count <= wr_data[sra_pkg::FCOUNT_W-1:0];
      endcase
    end
  end

  // intake and classification
  sra_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // execution
  sra_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WINDOW_MAX  (WINDOW_MAX)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .win_limit   (win_limit),
    .frame_count (frame_count),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

endmodule

@@ src/sra_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_ram - generic single write, single read memory
// One write port and one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
module sra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sra_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_front - request intake and classification
// Takes request beats, decodes them into commands and holds them in a
// two entry queue so the back end can stall without blocking intake.
// ----------------------------------------------------------------------------
module sra_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sra_pkg::req_t req,
  output logic          cmd_valid,
  output sra_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  localparam int DEPTH = 2;

  sra_pkg::cmd_t fifo [DEPTH];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic [1:0]    count_next;
  logic          push;
  sra_pkg::cmd_t decoded;

  // classify the action
  always_comb begin
    decoded = '{op: sra_pkg::OP_BAD};
    unique case (req.action)
      sra_pkg::ACT_START: decoded.op = sra_pkg::OP_START;
      sra_pkg::ACT_SEND:  decoded.op = sra_pkg::OP_SEND;
      sra_pkg::ACT_ACK:   decoded.op = req.ack_ok ? sra_pkg::OP_ACK_OK : sra_pkg::OP_ACK_LOST;
      sra_pkg::ACT_UNDEF: decoded.op = sra_pkg::OP_BAD;
    endcase
  end

  assign req_stall = (count == 2'(DEPTH));
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = fifo[rd_ptr];

  // occupancy
  always_comb begin
    unique case ({push, cmd_pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= decoded;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

@@ src/sra_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_back - command execution
// Sequencer over the pending frame queue and the outstanding frame store.
// Loads the queue on start, pops a window of frames on send, settles one
// frame per acknowledgement, and drives the result register.
// ----------------------------------------------------------------------------
module sra_back #(
  parameter int QUEUE_DEPTH = sra_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int WINDOW_MAX  = sra_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  sra_pkg::cmd_t                  cmd,
  output logic                           cmd_pop,
  input  logic [sra_pkg::WINDOW_W-1:0]   win_limit,
  input  logic [sra_pkg::FCOUNT_W-1:0]   frame_count,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output sra_pkg::rsp_t                  rsp
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int WW = $clog2(WINDOW_MAX + 1);
  localparam int OW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int NW = (FW > sra_pkg::FRAME_W) ? FW : sra_pkg::FRAME_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SEND,
    S_ACK,
    S_EMIT
  } state_t;

  state_t                          state, state_next;
  logic [QW-1:0]                   head, head_next;
  logic [QW-1:0]                   tail, tail_next;
  logic [FW-1:0]                   fill, fill_next;
  logic [WW-1:0]                   total, total_next;
  logic [WW-1:0]                   settle, settle_next;
  logic [WW-1:0]                   win, win_next;
  logic [FW-1:0]                   load_cnt, load_cnt_next;
  logic [FW-1:0]                   load_n, load_n_next;
  logic                            ack_good, ack_good_next;
  logic [sra_pkg::COUNT_W-1:0]     sent, sent_next;
  logic [sra_pkg::COUNT_W-1:0]     acked, acked_next;
  logic [sra_pkg::STATUS_W-1:0]    res_status, res_status_next;
  logic                            res_done, res_done_next;
  logic                            rsp_valid_next;
  sra_pkg::rsp_t                   rsp_next;

  // memory ports
  logic                            pq_we;
  logic [QW-1:0]                   pq_waddr;
  logic [sra_pkg::FRAME_W-1:0]     pq_wdata;
  logic [sra_pkg::FRAME_W-1:0]     pq_rdata;
  logic                            ob_we;
  logic [OW-1:0]                   ob_waddr;
  logic [sra_pkg::FRAME_W-1:0]     ob_rdata;

  logic                            slot_free;
  logic                            rsp_load;
  logic                            done_now;
  logic [NW-1:0]                   fc_ext;
  logic [NW-1:0]                   fc_clamped;
  logic [WW-1:0]                   win_clamped;

  function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] idx);
    return (idx == QW'(QUEUE_DEPTH - 1)) ? '0 : idx + QW'(1);
  endfunction

  // pending frame queue; read always follows the next head
  sra_ram #(
    .WIDTH (sra_pkg::FRAME_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_pending (
    .clk   (clk),
    .we    (pq_we),
    .waddr (pq_waddr),
    .wdata (pq_wdata),
    .raddr (head_next),
    .rdata (pq_rdata)
  );

  // outstanding frames of the current round; read follows the next settle slot
  sra_ram #(
    .WIDTH (sra_pkg::FRAME_W),
    .DEPTH (WINDOW_MAX)
  ) u_outstanding (
    .clk   (clk),
    .we    (ob_we),
    .waddr (ob_waddr),
    .wdata (pq_rdata),
    .raddr (settle_next[OW-1:0]),
    .rdata (ob_rdata)
  );

  // clamped configuration
  assign fc_ext     = NW'(frame_count);
  assign fc_clamped = (fc_ext > NW'(QUEUE_DEPTH)) ? NW'(QUEUE_DEPTH) : fc_ext;

  always_comb begin
    if (win_limit == '0) begin
      win_clamped = WW'(1);
    end else if (win_limit > sra_pkg::WINDOW_W'(WINDOW_MAX)) begin
      win_clamped = WW'(WINDOW_MAX);
    end else begin
      win_clamped = WW'(win_limit);
    end
  end

  assign slot_free = !rsp_valid || !rsp_stall;
  assign done_now  = (fill == '0) && (settle >= total);

  // sequencer
  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    fill_next       = fill;
    total_next      = total;
    settle_next     = settle;
    win_next        = win;
    load_cnt_next   = load_cnt;
    load_n_next     = load_n;
    ack_good_next   = ack_good;
    sent_next       = sent;
    acked_next      = acked;
    res_status_next = res_status;
    res_done_next   = res_done;
    pq_we           = 1'b0;
    pq_waddr        = tail;
    pq_wdata        = ob_rdata;
    ob_we           = 1'b0;
    ob_waddr        = total[OW-1:0];
    cmd_pop         = 1'b0;
    rsp_load        = 1'b0;
    rsp_next        = rsp;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop         = 1'b1;
          res_status_next = sra_pkg::ST_REJECT;
          res_done_next   = done_now;
          state_next      = S_EMIT;
          unique case (cmd.op)
            sra_pkg::OP_START: begin
              head_next       = '0;
              tail_next       = '0;
              fill_next       = '0;
              total_next      = '0;
              settle_next     = '0;
              sent_next       = '0;
              acked_next      = '0;
              load_cnt_next   = '0;
              load_n_next     = FW'(fc_clamped);
              res_status_next = sra_pkg::ST_STARTED;
              res_done_next   = (fc_clamped == '0);
              state_next      = (fc_clamped == '0) ? S_EMIT : S_LOAD;
            end
            sra_pkg::OP_SEND: begin
              if (settle < total) begin
                res_status_next = sra_pkg::ST_REJECT;
              end else if (fill == '0) begin
                res_status_next = sra_pkg::ST_EMPTY;
              end else begin
                win_next    = win_clamped;
                total_next  = '0;
                settle_next = '0;
                state_next  = S_SEND;
              end
            end
            sra_pkg::OP_ACK_OK, sra_pkg::OP_ACK_LOST: begin
              if (settle < total) begin
                ack_good_next = (cmd.op == sra_pkg::OP_ACK_OK);
                state_next    = S_ACK;
              end
            end
            default: begin
              res_status_next = sra_pkg::ST_REJECT;
            end
          endcase
        end
      end

      // one queue entry written per cycle
      S_LOAD: begin
        pq_we         = 1'b1;
        pq_waddr      = load_cnt[QW-1:0];
        load_cnt_next = load_cnt + FW'(1);
        pq_wdata      = sra_pkg::FRAME_W'(load_cnt_next);
        if (load_cnt_next == load_n) begin
          fill_next  = load_n;
          tail_next  = (load_n == FW'(QUEUE_DEPTH)) ? '0 : load_n[QW-1:0];
          state_next = S_EMIT;
        end
      end

      // one frame per free output slot
      S_SEND: begin
        if (slot_free) begin
          ob_we      = 1'b1;
          total_next = total + WW'(1);
          head_next  = wrap_inc(head);
          fill_next  = fill - FW'(1);
          sent_next  = (sent == '1) ? sent : sent + sra_pkg::COUNT_W'(1);
          rsp_load   = 1'b1;
          rsp_next   = '{
            frame_number:  pq_rdata,
            status:        sra_pkg::ST_SENT,
            last:          (total_next == win) || (fill_next == '0),
            transfer_done: (fill_next == '0) && (settle >= total_next),
            sent_count:    sent_next,
            acked_count:   acked
          };
          if ((total_next == win) || (fill_next == '0)) begin
            state_next = S_IDLE;
          end
        end
      end

      // settle the oldest outstanding frame
      S_ACK: begin
        if (slot_free) begin
          settle_next     = settle + WW'(1);
          res_status_next = sra_pkg::ST_LOST;
          if (ack_good) begin
            acked_next      = (acked == '1) ? acked : acked + sra_pkg::COUNT_W'(1);
            res_status_next = sra_pkg::ST_ACKED;
          end else if (fill < FW'(QUEUE_DEPTH)) begin
            pq_we     = 1'b1;
            pq_waddr  = tail;
            pq_wdata  = ob_rdata;
            tail_next = wrap_inc(tail);
            fill_next = fill + FW'(1);
          end
          rsp_load   = 1'b1;
          rsp_next   = '{
            frame_number:  ob_rdata,
            status:        res_status_next,
            last:          1'b1,
            transfer_done: (fill_next == '0) && (settle_next >= total),
            sent_count:    sent,
            acked_count:   acked_next
          };
          state_next = S_IDLE;
        end
      end

      // single result with no frame
      S_EMIT: begin
        if (slot_free) begin
          rsp_load   = 1'b1;
          rsp_next   = '{
            frame_number:  '0,
            status:        res_status,
            last:          1'b1,
            transfer_done: res_done,
            sent_count:    sent,
            acked_count:   acked
          };
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    rsp_valid_next = rsp_load ? 1'b1 : (rsp_valid && rsp_stall);
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      total     <= '0;
      settle    <= '0;
      sent      <= '0;
      acked     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      fill      <= fill_next;
      total     <= total_next;
      settle    <= settle_next;
      sent      <= sent_next;
      acked     <= acked_next;
      rsp_valid <= rsp_valid_next;
    end
    win        <= win_next;
    load_cnt   <= load_cnt_next;
    load_n     <= load_n_next;
    ack_good   <= ack_good_next;
    res_status <= res_status_next;
    res_done   <= res_done_next;
    rsp        <= rsp_next;
  end

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst) fill <= FW'(QUEUE_DEPTH))
    else $error("pending queue fill above depth");

  // settling never passes the round
  assert property (@(posedge clk) disable iff (rst) settle <= total)
    else $error("settle index beyond outstanding total");

  // a round never exceeds the window limit
  assert property (@(posedge clk) disable iff (rst) total <= WW'(WINDOW_MAX))
    else $error("outstanding total above window limit");

  // sending only pops a non-empty queue
  assert property (@(posedge clk) disable iff (rst) (state == S_SEND) |-> (fill != '0))
    else $error("send round on empty queue");

  // a finished round lands back in idle with frames recorded
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) && (state_next == S_IDLE) |=> (total != '0) && (settle == '0))
    else $error("send round closed without outstanding frames");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - selective repeat sender, self-checking bench
// Drives request beats through a valid/stall channel and keeps its own model
// of the queue, the outstanding window and the totals. Each result beat is
// checked field by field against the oldest prediction. Directed tests cover
// the corner cases; random traffic then runs mostly well-formed transfers
// under three idling patterns and several register settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QDEPTH = sra_pkg::QUEUE_DEPTH_DEFAULT;
  localparam int WMAX   = sra_pkg::WINDOW_MAX_DEFAULT;
  localparam int CW     = sra_pkg::COUNT_W;
  localparam int FW     = sra_pkg::FRAME_W;

  logic                           clk;
  logic                           rst       = 1'b1;
  logic                           req_valid = 1'b0;
  logic                           req_stall;
  sra_pkg::req_t                  req       = '0;
  logic                           rsp_valid;
  logic                           rsp_stall = 1'b0;
  sra_pkg::rsp_t                  rsp;
  logic                           wr_en     = 1'b0;
  logic [sra_pkg::CFG_IDX_W-1:0]  wr_index  = '0;
  logic [sra_pkg::CFG_DATA_W-1:0] wr_data   = '0;

  // idling odds in percent per cycle
  int unsigned gap_pct  = 0;
  int unsigned hold_pct = 0;
  int unsigned mismatch_count = 0;

  // predicted result beats, oldest first
  sra_pkg::rsp_t awaited_rsp[$];

  // sender model state
  logic [sra_pkg::WINDOW_W-1:0] window_reg = sra_pkg::WINDOW_RESET;
  logic [sra_pkg::FCOUNT_W-1:0] fcount_reg = sra_pkg::FCOUNT_RESET;
  logic [FW-1:0]                pend_mem [QDEPTH];
  int unsigned                  q_head = 0;
  int unsigned                  q_tail = 0;
  int unsigned                  q_fill = 0;
  logic [FW-1:0]                flight_mem [WMAX];
  int unsigned                  flight_total = 0;
  int unsigned                  settle_idx = 0;
  logic [CW-1:0]                sent_tot = '0;
  logic [CW-1:0]                acked_tot = '0;

  selective_repeat_retransmit_queue_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- model
  function automatic void enqueue_frame(input logic [FW-1:0] f);
    if (q_fill >= QDEPTH) return;
    pend_mem[q_tail] = f;
    q_tail = (q_tail + 1 >= QDEPTH) ? 0 : q_tail + 1;
    q_fill++;
  endfunction

  function automatic logic [FW-1:0] dequeue_frame();
    logic [FW-1:0] f;
    f = pend_mem[q_head];
    q_head = (q_head + 1 >= QDEPTH) ? 0 : q_head + 1;
    q_fill--;
    return f;
  endfunction

  // done flag and totals are taken after this beat's update
  function automatic void post_result(input logic [FW-1:0] f,
                                      input logic [sra_pkg::STATUS_W-1:0] st,
                                      input logic is_last);
    sra_pkg::rsp_t b;
    b.frame_number  = f;
    b.status        = st;
    b.last          = is_last;
    b.transfer_done = (q_fill == 0) && (settle_idx >= flight_total);
    b.sent_count    = sent_tot;
    b.acked_count   = acked_tot;
    awaited_rsp.push_back(b);
  endfunction

  function automatic void advance_sender(input sra_pkg::req_t r);
    int unsigned n;
    int unsigned win;
    int unsigned i;
    logic [FW-1:0] f;
    case (r.action)
      sra_pkg::ACT_START: begin
        n = (int'(fcount_reg) > QDEPTH) ? QDEPTH : int'(fcount_reg);
        q_head = 0;
        q_tail = 0;
        q_fill = 0;
        flight_total = 0;
        settle_idx = 0;
        sent_tot = '0;
        acked_tot = '0;
        for (i = 1; i <= n; i++) enqueue_frame(FW'(i));
        post_result('0, sra_pkg::ST_STARTED, 1'b1);
      end
      sra_pkg::ACT_SEND: begin
        if (settle_idx < flight_total) begin
          post_result('0, sra_pkg::ST_REJECT, 1'b1);
        end else if (q_fill == 0) begin
          post_result('0, sra_pkg::ST_EMPTY, 1'b1);
        end else begin
          win = int'(window_reg);
          if (win == 0) win = 1;
          if (win > WMAX) win = WMAX;
          flight_total = 0;
          settle_idx = 0;
          n = 0;
          while (n < win && q_fill != 0) begin
            f = dequeue_frame();
            flight_mem[n] = f;
            n++;
            flight_total = n;
            if (sent_tot != '1) sent_tot++;
            post_result(f, sra_pkg::ST_SENT, (n == win) || (q_fill == 0));
          end
        end
      end
      sra_pkg::ACT_ACK: begin
        if (settle_idx >= flight_total || settle_idx >= WMAX) begin
          post_result('0, sra_pkg::ST_REJECT, 1'b1);
        end else begin
          f = flight_mem[settle_idx];
          settle_idx++;
          if (r.ack_ok) begin
            if (acked_tot != '1) acked_tot++;
            post_result(f, sra_pkg::ST_ACKED, 1'b1);
          end else begin
            enqueue_frame(f);
            post_result(f, sra_pkg::ST_LOST, 1'b1);
          end
        end
      end
      default: begin
        post_result('0, sra_pkg::ST_REJECT, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checker
  function automatic void compare_field(input string name, input logic [CW-1:0] want,
                                        input logic [CW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    sra_pkg::rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (awaited_rsp.size() == 0) begin
        $error("result beat with nothing awaited: frame_number %0d status %0d",
               rsp.frame_number, rsp.status);
        mismatch_count++;
      end else begin
        want = awaited_rsp.pop_front();
        compare_field("frame_number", CW'(want.frame_number), CW'(rsp.frame_number));
        compare_field("status", CW'(want.status), CW'(rsp.status));
        compare_field("last", CW'(want.last), CW'(rsp.last));
        compare_field("transfer_done", CW'(want.transfer_done), CW'(rsp.transfer_done));
        compare_field("sent_count", want.sent_count, rsp.sent_count);
        compare_field("acked_count", want.acked_count, rsp.acked_count);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < hold_pct);
  end

  // ---------------------------------------------------------------- drivers
  function automatic sra_pkg::req_t make_req(input logic [1:0] act, input logic ok);
    sra_pkg::req_t r;
    r.action = act;
    r.ack_ok = ok;
    return r;
  endfunction

  // one request beat, with a random gap ahead of it
  task automatic push_request(input sra_pkg::req_t r);
    int unsigned n_gap;
    n_gap = 0;
    while ($urandom_range(99) < gap_pct) n_gap++;
    if (n_gap != 0) begin
      req_valid <= 1'b0;
      repeat (n_gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    advance_sender(r);
  endtask

  // wait until every awaited beat is in and the back end has wound down
  task automatic drain_block();
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write; the caller drops the enable afterwards
  task automatic write_register(input logic [sra_pkg::CFG_IDX_W-1:0] idx,
                                input logic [sra_pkg::CFG_DATA_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    if (idx == sra_pkg::REG_WIN_LIMIT) window_reg = val[sra_pkg::WINDOW_W-1:0];
    else fcount_reg = val[sra_pkg::FCOUNT_W-1:0];
  endtask

  task automatic set_registers(input logic [sra_pkg::CFG_DATA_W-1:0] win,
                               input logic [sra_pkg::CFG_DATA_W-1:0] cnt);
    drain_block();
    write_register(sra_pkg::REG_WIN_LIMIT, win);
    write_register(sra_pkg::REG_FRAME_COUNT, cnt);
    wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests
  // send, ack and the undefined action before any start
  task automatic test_idle_actions();
    push_request(make_req(sra_pkg::ACT_SEND, 1'b0));
    push_request(make_req(sra_pkg::ACT_ACK, 1'b1));
    push_request(make_req(sra_pkg::ACT_UNDEF, 1'b0));
    push_request(make_req(sra_pkg::ACT_UNDEF, 1'b1));
  endtask

  // one transfer at the reset settings: rejects, losses and a second send round
  task automatic test_default_round();
    push_request(make_req(sra_pkg::ACT_START, 1'b1));
    push_request(make_req(sra_pkg::ACT_SEND, 1'b0));
    push_request(make_req(sra_pkg::ACT_SEND, 1'b1));
    push_request(make_req(sra_pkg::ACT_ACK, 1'b1));
    push_request(make_req(sra_pkg::ACT_ACK, 1'b0));
    push_request(make_req(sra_pkg::ACT_ACK, 1'b1));
    push_request(make_req(sra_pkg::ACT_ACK, 1'b0));
    push_request(make_req(sra_pkg::ACT_ACK, 1'b1));
    push_request(make_req(sra_pkg::ACT_SEND, 1'b1));
  endtask

  // zero and over-range register values, then the smallest transfer
  task automatic test_register_extremes();
    set_registers(8'd0, 8'd0);
    push_request(make_req(sra_pkg::ACT_START, 1'b0));
    push_request(make_req(sra_pkg::ACT_SEND, 1'b0));
    push_request(make_req(sra_pkg::ACT_ACK, 1'b0));
    set_registers(8'd127, 8'd255);
    push_request(make_req(sra_pkg::ACT_START, 1'b0));
    push_request(make_req(sra_pkg::ACT_SEND, 1'b1));
    push_request(make_req(sra_pkg::ACT_UNDEF, 1'b1));
    push_request(make_req(sra_pkg::ACT_START, 1'b0));
    set_registers(8'd1, 8'd1);
    push_request(make_req(sra_pkg::ACT_START, 1'b1));
    push_request(make_req(sra_pkg::ACT_SEND, 1'b0));
    push_request(make_req(sra_pkg::ACT_ACK, 1'b0));
    push_request(make_req(sra_pkg::ACT_SEND, 1'b0));
    push_request(make_req(sra_pkg::ACT_ACK, 1'b1));
    push_request(make_req(sra_pkg::ACT_SEND, 1'b1));
  endtask

  // mostly well-formed transfers, one beat in ten random noise
  task automatic run_traffic(input int unsigned budget);
    int unsigned k;
    sra_pkg::req_t r;
    for (k = 0; k < budget; k++) begin
      if ($urandom_range(99) < 10) begin
        r = make_req(2'($urandom_range(3)), 1'($urandom_range(1)));
      end else if (settle_idx < flight_total) begin
        r = make_req(sra_pkg::ACT_ACK, $urandom_range(99) < 70);
      end else if (q_fill != 0) begin
        r = make_req(sra_pkg::ACT_SEND, 1'($urandom_range(1)));
      end else begin
        r = make_req(sra_pkg::ACT_START, 1'($urandom_range(1)));
      end
      push_request(r);
    end
  endtask

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct);
    int unsigned chunk;
    logic [sra_pkg::CFG_DATA_W-1:0] win;
    logic [sra_pkg::CFG_DATA_W-1:0] cnt;
    gap_pct  = snd_pct;
    hold_pct = rcv_pct;
    for (chunk = 0; chunk < 3; chunk++) begin
      case ($urandom_range(7))
        0:       win = 8'd0;
        1:       win = 8'd1;
        2:       win = 8'(WMAX);
        3:       win = 8'($urandom_range(127, WMAX + 1));
        default: win = 8'($urandom_range(16, 1));
      endcase
      case ($urandom_range(7))
        0:       cnt = 8'd0;
        1:       cnt = 8'd1;
        2:       cnt = 8'(QDEPTH);
        3:       cnt = 8'($urandom_range(255, QDEPTH + 1));
        default: cnt = 8'($urandom_range(24, 2));
      endcase
      set_registers(win, cnt);
      run_traffic(49);
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gap_pct  = 11;
    hold_pct = 73;
    test_idle_actions();
    test_default_round();
    test_register_extremes();
    test_random_traffic(11, 73);
    test_random_traffic(73, 11);
    test_random_traffic(0, 0);
    drain_block();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
src/sra_pkg.sv
src/sra_ram.sv
src/sra_front.sv
src/sra_back.sv
src/selective_repeat_retransmit_queue_top.sv
dv/testbench.sv
